// ===== rtl/telnet_option_negotiator_assert.svh =====
// Assertion helpers for the telnet option negotiator.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef TELNET_OPTION_NEGOTIATOR_ASSERT_SVH
`define TELNET_OPTION_NEGOTIATOR_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define TON_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("telnet option negotiator: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define TON_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("telnet option negotiator: assertion failed");

`endif

// ===== rtl/ton_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ton_pkg;

	// Option number width and default table depth
	localparam int OPT_W = 8;
	localparam int TON_NUM_OPTIONS = 256;

	// Item opcodes
	localparam logic [2:0] OP_GOT_WILL = 3'd0;
	localparam logic [2:0] OP_GOT_WONT = 3'd1;
	localparam logic [2:0] OP_GOT_DO   = 3'd2;
	localparam logic [2:0] OP_GOT_DONT = 3'd3;
	localparam logic [2:0] OP_ENABLE   = 3'd4;
	localparam logic [2:0] OP_DISABLE  = 3'd5;
	localparam logic [2:0] OP_QUERY    = 3'd6;

	// Telnet commands as sent on the reply
	localparam logic [1:0] CMD_WILL = 2'd0;
	localparam logic [1:0] CMD_WONT = 2'd1;
	localparam logic [1:0] CMD_DO   = 2'd2;
	localparam logic [1:0] CMD_DONT = 2'd3;

	// Q-method negotiation states
	typedef enum logic [2:0] {
		QS_NO        = 3'd0,
		QS_WANTYES   = 3'd1,
		QS_WANTYESNO = 3'd2,
		QS_YES       = 3'd3,
		QS_WANTNO    = 3'd4,
		QS_WANTNOYES = 3'd5
	} qstate_t;

	// Request transaction
	typedef struct packed {
		logic [2:0]       opcode;
		logic [OPT_W-1:0] option_code;
		logic             side;
		logic             accept;
	} req_t;

	// Response transaction
	typedef struct packed {
		logic             send_valid;
		logic [1:0]       send_command;
		logic [OPT_W-1:0] sent_option;
		logic             toggle_valid;
		logic             toggle_side;
		logic             toggle_on;
		logic             local_enabled;
		logic             remote_enabled;
		logic             asked_enabled;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ton_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Valid/ready channel carrying one payload per transaction
interface ton_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/telnet_option_negotiator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Telnet option negotiator (RFC 1143 Q method). Keeps a local and a remote
// negotiation state for each of NUM_OPTIONS options, all NO after reset; a
// per-option valid flop makes the reset take effect at once, so there is no
// clearing pass. Each request transaction (received WILL/WONT/DO/DONT,
// enable, disable or query) yields exactly one response transaction with an
// optional reply command, an optional toggle event and the enabled view.
// One request is accepted every cycle unless stage 1 and the output register
// are both full and rsp.ready is low. Each request goes from the stage 1
// registers to the output register. The state table is read at accept and
// written as stage 1 advances, with the pending write forwarded to a request
// for the same option right behind. Options >= NUM_OPTIONS read as NO, unstored.
module telnet_option_negotiator #(
	parameter int NUM_OPTIONS = ton_pkg::TON_NUM_OPTIONS
) (
	input  logic              clk,
	input  logic              arst_n,
	ton_stream_if.sink        req,
	ton_stream_if.source      rsp
);
	import ton_pkg::*;

	`include "telnet_option_negotiator_assert.svh"

	localparam int IDX_W = $clog2(NUM_OPTIONS);
	localparam logic [OPT_W:0] OPT_LIMIT = (OPT_W + 1)'(NUM_OPTIONS);

	typedef struct packed {
		qstate_t    q;
		logic       snd;
		logic [1:0] cmd;
		logic       tog;
	} peer_res_t;

	// Reaction to a received WILL or DO
	function automatic peer_res_t peer_positive(qstate_t q, logic acc,
			logic [1:0] yes_cmd, logic [1:0] no_cmd);
		peer_res_t r;
		r = '{q: q, snd: 1'b0, cmd: CMD_WILL, tog: 1'b0};
		unique case (q)
			QS_NO: begin
				r.snd = 1'b1;
				if (acc) begin
					r.cmd = yes_cmd;
					r.tog = 1'b1;
					r.q   = QS_YES;
				end else begin
					r.cmd = no_cmd;
				end
			end
			QS_WANTNO: r.q = QS_NO;
			QS_WANTNOYES, QS_WANTYES: begin
				r.tog = 1'b1;
				r.q   = QS_YES;
			end
			QS_WANTYESNO: begin
				r.snd = 1'b1;
				r.cmd = no_cmd;
				r.tog = 1'b1;
				r.q   = QS_WANTNO;
			end
			default: r.q = q;
		endcase
		return r;
	endfunction

	// Reaction to a received WONT or DONT
	function automatic peer_res_t peer_negative(qstate_t q,
			logic [1:0] yes_cmd, logic [1:0] no_cmd);
		peer_res_t r;
		r = '{q: q, snd: 1'b0, cmd: CMD_WILL, tog: 1'b0};
		unique case (q)
			QS_YES: begin
				r.snd = 1'b1;
				r.cmd = no_cmd;
				r.tog = 1'b1;
				r.q   = QS_NO;
			end
			QS_WANTNO, QS_WANTYES, QS_WANTYESNO: r.q = QS_NO;
			QS_WANTNOYES: begin
				r.snd = 1'b1;
				r.cmd = yes_cmd;
				r.q   = QS_WANTYES;
			end
			default: r.q = q;
		endcase
		return r;
	endfunction

	function automatic logic is_enabled(qstate_t q);
		return (q == QS_YES) || (q == QS_WANTNO) || (q == QS_WANTNOYES);
	endfunction

	// State table: {remote, local} per option, plus per-option valid flops
	logic [5:0]             table_mem [NUM_OPTIONS];
	logic [NUM_OPTIONS-1:0] entry_vld_q;

	// Stage 1 registers
	logic             valid_s1;
	logic [2:0]       opcode_s1;
	logic [OPT_W-1:0] opt_s1;
	logic             side_s1;
	logic             acc_s1;
	logic             inrange_s1;
	logic             vld_s1;
	logic [5:0]       rd_s1;
	logic             hit_s1;
	logic [5:0]       fwd_s1;

	// Output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic             in_fire;
	logic             s1_adv;
	logic             in_range;
	logic [IDX_W-1:0] in_idx;
	logic [IDX_W-1:0] wr_idx;
	logic             wr_en;
	qstate_t          lq_n;
	qstate_t          rq_n;
	rsp_t             rsp_n;

	// Handshake
	assign s1_adv    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_adv;
	assign in_fire   = req.valid && req.ready;
	assign in_range  = {1'b0, req.payload.option_code} < OPT_LIMIT;
	assign in_idx    = req.payload.option_code[IDX_W-1:0];
	assign wr_idx    = opt_s1[IDX_W-1:0];
	assign wr_en     = s1_adv && inrange_s1;

	// Stage 1 control and valid flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			entry_vld_q <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				entry_vld_q[wr_idx] <= 1'b1;
			end
		end
	end

	// Stage 1 payload, table read and forwarding of the pending write
	always_ff @(posedge clk) begin
		if (in_fire) begin
			opcode_s1  <= req.payload.opcode;
			opt_s1     <= req.payload.option_code;
			side_s1    <= req.payload.side;
			acc_s1     <= req.payload.accept;
			inrange_s1 <= in_range;
			vld_s1     <= in_range && entry_vld_q[in_idx];
			hit_s1     <= wr_en && (opt_s1 == req.payload.option_code);
			fwd_s1     <= {rq_n, lq_n};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_idx] <= {rq_n, lq_n};
		end
		if (in_fire) begin
			rd_s1 <= table_mem[in_idx];
		end
	end

	// Next state and response for the item in stage 1
	always_comb begin
		logic [5:0] cur;
		logic [2:0] op;
		logic       acc;
		qstate_t    lq;
		qstate_t    rq;
		qstate_t    q;
		peer_res_t  pr;
		logic       snd;
		logic [1:0] cmd;
		logic       tog;
		logic       tside;
		logic       ton;

		if (hit_s1) begin
			cur = fwd_s1;
		end else if (vld_s1) begin
			cur = rd_s1;
		end else begin
			cur = {QS_NO, QS_NO};
		end
		lq  = inrange_s1 ? qstate_t'(cur[2:0]) : QS_NO;
		rq  = inrange_s1 ? qstate_t'(cur[5:3]) : QS_NO;
		op  = opcode_s1;
		acc = acc_s1 && inrange_s1;
		if (!inrange_s1 && (op >= OP_ENABLE)) begin
			op = OP_QUERY;
		end
		snd   = 1'b0;
		cmd   = CMD_WILL;
		tog   = 1'b0;
		tside = 1'b0;
		ton   = 1'b0;
		pr    = '{q: QS_NO, snd: 1'b0, cmd: CMD_WILL, tog: 1'b0};
		q     = side_s1 ? rq : lq;

		case (op)
			OP_GOT_WILL: begin
				pr    = peer_positive(rq, acc, CMD_DO, CMD_DONT);
				rq    = pr.q;
				snd   = pr.snd;
				cmd   = pr.cmd;
				tog   = pr.tog;
				tside = 1'b1;
				ton   = 1'b1;
			end
			OP_GOT_WONT: begin
				pr    = peer_negative(rq, CMD_DO, CMD_DONT);
				rq    = pr.q;
				snd   = pr.snd;
				cmd   = pr.cmd;
				tog   = pr.tog;
				tside = 1'b1;
			end
			OP_GOT_DO: begin
				pr  = peer_positive(lq, acc, CMD_WILL, CMD_WONT);
				lq  = pr.q;
				snd = pr.snd;
				cmd = pr.cmd;
				tog = pr.tog;
				ton = 1'b1;
			end
			OP_GOT_DONT: begin
				pr  = peer_negative(lq, CMD_WILL, CMD_WONT);
				lq  = pr.q;
				snd = pr.snd;
				cmd = pr.cmd;
				tog = pr.tog;
			end
			OP_ENABLE: begin
				if (q == QS_NO) begin
					q   = QS_WANTYES;
					snd = 1'b1;
					cmd = side_s1 ? CMD_DO : CMD_WILL;
				end else if (q == QS_WANTNO) begin
					q = QS_WANTNOYES;
				end else if (q == QS_WANTYESNO) begin
					q = QS_WANTYES;
				end
				if (side_s1) rq = q; else lq = q;
			end
			OP_DISABLE: begin
				if (q == QS_YES) begin
					q     = QS_WANTNO;
					snd   = 1'b1;
					cmd   = side_s1 ? CMD_DONT : CMD_WONT;
					tog   = 1'b1;
					tside = side_s1;
				end else if (q == QS_WANTNOYES) begin
					q = QS_WANTNO;
				end else if (q == QS_WANTYES) begin
					q = QS_WANTYESNO;
				end
				if (side_s1) rq = q; else lq = q;
			end
			default: begin
				// query and the unused code: no change
			end
		endcase

		lq_n = lq;
		rq_n = rq;

		rsp_n.send_valid     = snd;
		rsp_n.send_command   = snd ? cmd : CMD_WILL;
		rsp_n.sent_option    = snd ? opt_s1 : '0;
		rsp_n.toggle_valid   = tog;
		rsp_n.toggle_side    = tog && tside;
		rsp_n.toggle_on      = tog && ton;
		rsp_n.local_enabled  = is_enabled(lq);
		rsp_n.remote_enabled = is_enabled(rq);
		rsp_n.asked_enabled  = side_s1 ? is_enabled(rq) : is_enabled(lq);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Checks
	`TON_ASSERT_NEXT(a_accept_fills_s1, req.valid && req.ready, valid_s1)
	`TON_ASSERT_NEXT(a_advance_fills_out, s1_adv, rsp_valid_q)
	`TON_ASSERT_SAME(a_write_in_range, wr_en, {1'b0, opt_s1} < OPT_LIMIT)
	`TON_ASSERT_SAME(a_no_send_clean, rsp_valid_q && !rsp_q.send_valid,
		rsp_q.send_command == CMD_WILL && rsp_q.sent_option == '0)
	`TON_ASSERT_SAME(a_no_toggle_clean, rsp_valid_q && !rsp_q.toggle_valid,
		!rsp_q.toggle_side && !rsp_q.toggle_on)

endmodule

`default_nettype wire

// ===== tb/sv/telnet_option_negotiator_test.sv =====
`timescale 1ns / 1ps

module telnet_option_negotiator_test;
	import ton_pkg::*;

	localparam int NUM_OPT = TON_NUM_OPTIONS;
	localparam int DIR_N = 28;
	localparam int RAND_N = 400;
	localparam int DRAIN_AT = DIR_N + 150;
	localparam int HOLD_AT = 60;
	localparam int HOLD_CYCLES = 250;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 10;

	// Opcode 7 is not defined by the block and must act as a query
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam rsp_t NO_RSP = '0;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;

	logic req_valid_r = 1'b0;
	req_t req_item_r = '0;
	logic rsp_ready_r = 1'b0;

	ton_stream_if #(.payload_t(req_t)) req_ch ();
	ton_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	assign req_ch.valid = req_valid_r;
	assign req_ch.payload = req_item_r;
	assign rsp_ch.ready = rsp_ready_r;

	telnet_option_negotiator #(.NUM_OPTIONS(NUM_OPT)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	// Shadow copy of the per-option negotiation table
	qstate_t local_tbl [NUM_OPT];
	qstate_t remote_tbl [NUM_OPT];

	stim_t stim_q[$];
	stim_t directed_rows [DIR_N];
	rsp_t  pending_rsp_q[$];

	int accepted_cnt = 0;
	int rsp_seen = 0;
	int errors = 0;
	int cycle_cnt = 0;

	function automatic logic is_on(input qstate_t q);
		return (q == QS_YES || q == QS_WANTNO || q == QS_WANTNOYES);
	endfunction

	// Received WILL or DO
	function automatic qstate_t after_offer(input qstate_t q, input logic acc,
			input logic [1:0] yes_cmd, input logic [1:0] no_cmd,
			output logic snd, output logic [1:0] cmd, output logic tog);
		qstate_t nq;
		nq = q;
		snd = 1'b0;
		cmd = CMD_WILL;
		tog = 1'b0;
		case (q)
			QS_NO: begin
				snd = 1'b1;
				if (acc) begin
					cmd = yes_cmd;
					tog = 1'b1;
					nq = QS_YES;
				end else begin
					cmd = no_cmd;
				end
			end
			QS_WANTNO: nq = QS_NO;
			QS_WANTNOYES, QS_WANTYES: begin
				tog = 1'b1;
				nq = QS_YES;
			end
			QS_WANTYESNO: begin
				snd = 1'b1;
				cmd = no_cmd;
				tog = 1'b1;
				nq = QS_WANTNO;
			end
			default: ;
		endcase
		return nq;
	endfunction

	// Received WONT or DONT
	function automatic qstate_t after_refusal(input qstate_t q,
			input logic [1:0] yes_cmd, input logic [1:0] no_cmd,
			output logic snd, output logic [1:0] cmd, output logic tog);
		qstate_t nq;
		nq = q;
		snd = 1'b0;
		cmd = CMD_WILL;
		tog = 1'b0;
		case (q)
			QS_YES: begin
				snd = 1'b1;
				cmd = no_cmd;
				tog = 1'b1;
				nq = QS_NO;
			end
			QS_WANTNO, QS_WANTYES, QS_WANTYESNO: nq = QS_NO;
			QS_WANTNOYES: begin
				snd = 1'b1;
				cmd = yes_cmd;
				nq = QS_WANTYES;
			end
			default: ;
		endcase
		return nq;
	endfunction

	// Apply one request to the shadow table and build the response it yields
	function automatic rsp_t negotiate(input req_t r);
		logic [2:0] op;
		logic       acc;
		logic       in_range;
		qstate_t    lq, rq, q;
		logic       snd, tog, tside, ton;
		logic [1:0] cmd;
		rsp_t       res;

		op = r.opcode;
		acc = r.accept;
		in_range = (int'(r.option_code) < NUM_OPT);
		lq = QS_NO;
		rq = QS_NO;
		if (in_range) begin
			lq = local_tbl[r.option_code];
			rq = remote_tbl[r.option_code];
		end else begin
			acc = 1'b0;
			if (op >= OP_ENABLE)
				op = OP_QUERY;
		end
		snd = 1'b0;
		cmd = CMD_WILL;
		tog = 1'b0;
		tside = 1'b0;
		ton = 1'b0;

		case (op)
			OP_GOT_WILL: begin
				rq = after_offer(rq, acc, CMD_DO, CMD_DONT, snd, cmd, tog);
				tside = 1'b1;
				ton = 1'b1;
			end
			OP_GOT_WONT: begin
				rq = after_refusal(rq, CMD_DO, CMD_DONT, snd, cmd, tog);
				tside = 1'b1;
			end
			OP_GOT_DO: begin
				lq = after_offer(lq, acc, CMD_WILL, CMD_WONT, snd, cmd, tog);
				ton = 1'b1;
			end
			OP_GOT_DONT: begin
				lq = after_refusal(lq, CMD_WILL, CMD_WONT, snd, cmd, tog);
			end
			OP_ENABLE: begin
				q = r.side ? rq : lq;
				if (q == QS_NO) begin
					q = QS_WANTYES;
					snd = 1'b1;
					cmd = r.side ? CMD_DO : CMD_WILL;
				end else if (q == QS_WANTNO) begin
					q = QS_WANTNOYES;
				end else if (q == QS_WANTYESNO) begin
					q = QS_WANTYES;
				end
				if (r.side) rq = q; else lq = q;
			end
			OP_DISABLE: begin
				q = r.side ? rq : lq;
				if (q == QS_YES) begin
					q = QS_WANTNO;
					snd = 1'b1;
					cmd = r.side ? CMD_DONT : CMD_WONT;
					tog = 1'b1;
					tside = r.side;
				end else if (q == QS_WANTNOYES) begin
					q = QS_WANTNO;
				end else if (q == QS_WANTYES) begin
					q = QS_WANTYESNO;
				end
				if (r.side) rq = q; else lq = q;
			end
			default: ;
		endcase

		if (in_range) begin
			local_tbl[r.option_code] = lq;
			remote_tbl[r.option_code] = rq;
		end

		res.send_valid = snd;
		res.send_command = snd ? cmd : CMD_WILL;
		res.sent_option = snd ? r.option_code : '0;
		res.toggle_valid = tog;
		res.toggle_side = tog ? tside : 1'b0;
		res.toggle_on = tog ? ton : 1'b0;
		res.local_enabled = is_on(lq);
		res.remote_enabled = is_on(rq);
		res.asked_enabled = r.side ? is_on(rq) : is_on(lq);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch in response %0d, %s: got %0d, expected %0d",
			rsp_seen, field, got, want);
		errors++;
	endtask

	// Request side: bursts with random gaps, one drain pause mid-run
	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic taken;
		int   n;
		rsp_t predicted;
		int   burst_left;
		int   gap_left;
		if (!arst_n) begin
			req_valid_r <= 1'b0;
			req_item_r <= '0;
			accepted_cnt <= 0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			taken = req_valid_r && req_ch.ready;
			n = accepted_cnt;
			if (taken) begin
				predicted = negotiate(stim_q[n].item);
				pending_rsp_q.push_back(stim_q[n].typed ? stim_q[n].want : predicted);
				n++;
				accepted_cnt <= n;
			end
			if (req_valid_r && !taken) begin
				// transaction still on offer, keep it
			end else if (n >= stim_q.size() || (n == DRAIN_AT && rsp_seen < n)) begin
				req_valid_r <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				req_valid_r <= 1'b0;
			end else begin
				req_valid_r <= 1'b1;
				req_item_r <= stim_q[n].item;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Response side: rotating stall mask, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin : drive_ready
		int         hold_left;
		logic       hold_done;
		logic [7:0] stall_mask;
		logic [5:0] mask_phase;
		if (!arst_n) begin
			rsp_ready_r <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
			stall_mask = 8'hFF;
			mask_phase = '0;
		end else if (hold_left > 0) begin
			rsp_ready_r <= 1'b0;
			hold_left--;
		end else if (!hold_done && rsp_seen >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_ready_r <= 1'b0;
		end else begin
			rsp_ready_r <= stall_mask[mask_phase[2:0]];
			if (mask_phase == 6'd63)
				stall_mask = ($urandom_range(0, 9) < 3) ? 8'hFF : (8'($urandom) | 8'h01);
			mask_phase++;
		end
	end

	// Compare each response transaction with the oldest prediction
	always @(posedge clk) begin : check_responses
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ready_r) begin
			got = rsp_ch.payload;
			if (pending_rsp_q.size() == 0) begin
				report_mismatch("unexpected response", 1, 0);
			end else begin
				want = pending_rsp_q.pop_front();
				if (got.send_valid !== want.send_valid)
					report_mismatch("send_valid", got.send_valid, want.send_valid);
				if (got.send_command !== want.send_command)
					report_mismatch("send_command", got.send_command, want.send_command);
				if (got.sent_option !== want.sent_option)
					report_mismatch("sent_option", got.sent_option, want.sent_option);
				if (got.toggle_valid !== want.toggle_valid)
					report_mismatch("toggle_valid", got.toggle_valid, want.toggle_valid);
				if (got.toggle_side !== want.toggle_side)
					report_mismatch("toggle_side", got.toggle_side, want.toggle_side);
				if (got.toggle_on !== want.toggle_on)
					report_mismatch("toggle_on", got.toggle_on, want.toggle_on);
				if (got.local_enabled !== want.local_enabled)
					report_mismatch("local_enabled", got.local_enabled, want.local_enabled);
				if (got.remote_enabled !== want.remote_enabled)
					report_mismatch("remote_enabled", got.remote_enabled, want.remote_enabled);
				if (got.asked_enabled !== want.asked_enabled)
					report_mismatch("asked_enabled", got.asked_enabled, want.asked_enabled);
			end
			rsp_seen <= rsp_seen + 1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		stim_t      s;
		logic [7:0] opt_pool [6];

		arst_n = 1'b0;
		foreach (local_tbl[i]) begin
			local_tbl[i] = QS_NO;
			remote_tbl[i] = QS_NO;
		end

		// Directed table: fixed responses where obvious, else predicted
		directed_rows = '{
			'{'{OP_QUERY,    8'd0,   1'b0, 1'b0}, 1'b1, NO_RSP},
			'{'{OP_QUERY,    8'd255, 1'b1, 1'b1}, 1'b1, NO_RSP},
			'{'{OP_GOT_WILL, 8'd255, 1'b0, 1'b0}, 1'b1,
				'{1'b1, CMD_DONT, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{'{OP_GOT_DO,   8'd0,   1'b1, 1'b0}, 1'b1,
				'{1'b1, CMD_WONT, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{'{OP_UNUSED,   8'd9,   1'b1, 1'b1}, 1'b1, NO_RSP},
			'{'{OP_GOT_WONT, 8'd5,   1'b0, 1'b1}, 1'b1, NO_RSP},
			'{'{OP_DISABLE,  8'd5,   1'b1, 1'b1}, 1'b1, NO_RSP},
			// peer asks, we accept, then peer backs out; DONT in YES answers WONT
			'{'{OP_GOT_WILL, 8'd1,   1'b0, 1'b1}, 1'b0, NO_RSP},
			'{'{OP_GOT_DO,   8'd1,   1'b1, 1'b1}, 1'b0, NO_RSP},
			'{'{OP_GOT_DONT, 8'd1,   1'b0, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_GOT_WONT, 8'd1,   1'b1, 1'b0}, 1'b0, NO_RSP},
			// local enable path, redundant commands, DO in WANTNO
			'{'{OP_ENABLE,   8'd2,   1'b0, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_ENABLE,   8'd2,   1'b0, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_GOT_DO,   8'd2,   1'b0, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_GOT_DO,   8'd2,   1'b0, 1'b1}, 1'b0, NO_RSP},
			'{'{OP_DISABLE,  8'd2,   1'b0, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_DISABLE,  8'd2,   1'b0, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_GOT_DO,   8'd2,   1'b0, 1'b1}, 1'b0, NO_RSP},
			// remote side through every Q state, WILL in WANTNOYES
			'{'{OP_ENABLE,   8'd254, 1'b1, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_DISABLE,  8'd254, 1'b1, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_GOT_WILL, 8'd254, 1'b1, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_ENABLE,   8'd254, 1'b1, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_GOT_WONT, 8'd254, 1'b1, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_GOT_WILL, 8'd254, 1'b1, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_DISABLE,  8'd254, 1'b1, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_ENABLE,   8'd254, 1'b1, 1'b0}, 1'b0, NO_RSP},
			'{'{OP_GOT_WILL, 8'd254, 1'b0, 1'b0}, 1'b0, NO_RSP},
			// DONT while waiting for our own WILL
			'{'{OP_ENABLE,   8'd3,   1'b0, 1'b1}, 1'b0, NO_RSP}
		};
		foreach (directed_rows[i])
			stim_q.push_back(directed_rows[i]);
		s.item = '{OP_GOT_DONT, 8'd3, 1'b0, 1'b1};
		s.typed = 1'b0;
		s.want = NO_RSP;
		stim_q.push_back(s);

		// Random part: mostly a small pool of options so states go deep
		opt_pool[0] = 8'd0;
		opt_pool[1] = 8'd255;
		for (int i = 2; i < 6; i++)
			opt_pool[i] = 8'($urandom);
		for (int k = 0; k < RAND_N; k++) begin
			s.item.opcode = ($urandom_range(0, 29) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
			s.item.option_code = ($urandom_range(0, 9) < 8) ? opt_pool[$urandom_range(0, 5)]
				: 8'($urandom);
			s.item.side = 1'($urandom);
			s.item.accept = ($urandom_range(0, 9) < 7);
			s.typed = 1'b0;
			s.want = NO_RSP;
			stim_q.push_back(s);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_cnt < stim_q.size() || rsp_seen < stim_q.size())
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_rsp_q.size() != 0)
			report_mismatch("missing responses", 0, pending_rsp_q.size());

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
